### rtl/lrb_pkg.sv
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared types and constants for the LRU residency budget manager.
// ----------------------------------------------------------------------------
package lrb_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int STAMP_W   = 32;
  localparam int BYTES_W   = 40;
  localparam int SUM_W     = 48;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 3;

  // Configuration port: one 48-bit register at byte address 0, 8-byte stride.
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 64;
  localparam int REG_SEL_B = 3;
  localparam logic REG_BUDGET = 1'b0;

  localparam logic [SUM_W-1:0]   BUDGET_RESET = 48'd33285996544;
  localparam logic [STAMP_W-1:0] STAMP_MAX    = '1;

  typedef enum logic [1:0] {
    TIER_COLD   = 2'd0,
    TIER_WARM   = 2'd1,
    TIER_HOT    = 2'd2,
    TIER_PINNED = 2'd3
  } tier_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_RESIDENT = 2'd0,
    REQ_MAP      = 2'd1,
    REQ_PIN      = 2'd2,
    REQ_UNPIN    = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_EVICTED   = 3'd0,
    ST_HIT       = 3'd1,
    ST_LOADED    = 3'd2,
    ST_OVER      = 3'd3,
    ST_ALREADY   = 3'd4,
    ST_MAPPED    = 3'd5,
    ST_PIN_DONE  = 3'd6,
    ST_UNUSED    = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_FIT,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_EVICT,
    S_LOAD,
    S_SIMPLE
  } state_t;

endpackage

### rtl/lrb_ram.sv
// ----------------------------------------------------------------------------
// lrb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lru_residency_budget_manager.sv
// ----------------------------------------------------------------------------
// lru_residency_budget_manager
// Per-slot residency tracking with LRU eviction under a byte budget.
// ----------------------------------------------------------------------------
// Usage: an item (req_type, req_slot, block_bytes) is taken when start is
// high and busy is low. busy stays high while the item is worked on. Every
// item gives one or more results on slot_id, status, resident_total and last,
// each shown for one cycle with result_valid high; the receiver cannot stall
// them. Eviction results carry last low, the final result carries last high.
// Map, pin and unpin are handled in the simple state; a make resident item
// goes through lookup and check, and on a miss through fit and load.
// Each eviction comes after a scan for the oldest stamp by one shared
// comparator that walks all 32 slots, one stamp RAM read per cycle.
// A scan that finds nothing left to evict goes on to the load.
// A new item may be started in the cycle in which the final result shows.
// Stamps and held sizes live in RAMs; per-slot valid bits make unwritten
// entries read as zero, so no clearing pass is needed after reset.
// Reset clears all tiers to cold, all slots unmapped, the tick and the byte
// total to zero, and loads the budget register with its default.
// The budget register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module lru_residency_budget_manager (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lrb_pkg::REQ_W-1:0]     req_type,
  input  logic [lrb_pkg::SLOT_W-1:0]    req_slot,
  input  logic [lrb_pkg::BYTES_W-1:0]   block_bytes,
  output logic                          result_valid,
  output logic [lrb_pkg::SLOT_W-1:0]    slot_id,
  output logic [lrb_pkg::STATUS_W-1:0]  status,
  output logic [lrb_pkg::SUM_W-1:0]     resident_total,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrb_pkg::PADDR_W-1:0]   paddr,
  input  logic [lrb_pkg::PDATA_W-1:0]   pwdata,
  output logic [lrb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import lrb_pkg::*;

  state_t state, state_next;

  req_t                 req_q;
  logic [SLOT_W-1:0]    id_q;
  logic [BYTES_W-1:0]   bytes_q;
  logic [STAMP_W-1:0]   tick;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     budget;

  tier_t                tier       [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] mapped;
  logic [NUM_SLOTS-1:0] stamp_vld;
  logic [NUM_SLOTS-1:0] held_vld;

  logic [SLOT_W-1:0]    scan_idx;
  logic                 cmp_vld;
  logic                 cmp_cand;
  logic [SLOT_W-1:0]    cmp_idx;
  logic [STAMP_W-1:0]   oldest;
  logic [SLOT_W-1:0]    pick;
  logic                 found;
  logic                 stamp_v_q;
  logic                 held_v_q;

  // RAM ports
  logic                 stamp_we;
  logic [SLOT_W-1:0]    stamp_waddr;
  logic [STAMP_W-1:0]   stamp_wdata;
  logic [SLOT_W-1:0]    stamp_raddr;
  logic [STAMP_W-1:0]   stamp_rdata;
  logic                 held_we;
  logic [SLOT_W-1:0]    held_raddr;
  logic [BYTES_W-1:0]   held_rdata;

  // Control outputs of the sequencer
  logic [SLOT_W-1:0]    tier_raddr;
  logic                 tier_we;
  logic [SLOT_W-1:0]    tier_waddr;
  tier_t                tier_wdata;
  logic                 map_set;
  logic                 held_clr;
  logic                 emit;
  logic [SLOT_W-1:0]    emit_slot;
  status_t              emit_status;
  logic [SUM_W-1:0]     emit_total;
  logic                 emit_last;

  // Datapath terms
  tier_t                tier_rd;
  logic                 cand;
  logic [BYTES_W-1:0]   held_val;
  logic [STAMP_W-1:0]   stamp_val;
  logic                 hit;
  logic [SUM_W:0]       fit_sum;
  logic                 fits;
  logic [SUM_W-1:0]     sum_evict;
  logic [SUM_W-1:0]     sum_load;
  logic                 accept;
  logic                 id_ok;
  logic                 cfg_wr;

  lrb_ram #(.WIDTH(STAMP_W), .DEPTH(NUM_SLOTS)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (stamp_wdata),
    .raddr (stamp_raddr),
    .rdata (stamp_rdata)
  );

  lrb_ram #(.WIDTH(BYTES_W), .DEPTH(NUM_SLOTS)) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (id_q),
    .wdata (bytes_q),
    .raddr (held_raddr),
    .rdata (held_rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign id_ok  = (SLOT_W+1)'(req_slot) < (SLOT_W+1)'(NUM_SLOTS);

  assign tier_rd   = tier[tier_raddr];
  assign cand      = (tier_rd == TIER_HOT) || (tier_rd == TIER_PINNED);
  assign held_val  = held_v_q ? held_rdata : '0;
  assign stamp_val = stamp_v_q ? stamp_rdata : '0;
  assign hit       = cand && (held_val != '0);
  assign fit_sum   = (SUM_W+1)'(sum) + (SUM_W+1)'(bytes_q);
  assign fits      = fit_sum <= (SUM_W+1)'(budget);
  assign sum_load  = fit_sum[SUM_W-1:0];
  // An impossible state could make the subtraction go below zero; clamp it.
  assign sum_evict = (sum >= SUM_W'(held_val)) ? (sum - SUM_W'(held_val)) : '0;

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[REG_SEL_B] == REG_BUDGET) ? PDATA_W'(budget) : '0;

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && id_ok) begin
          state_next = (req_t'(req_type) == REQ_RESIDENT) ? S_LOOKUP : S_SIMPLE;
        end
      end
      S_LOOKUP: state_next = S_CHECK;
      S_CHECK:  state_next = hit ? S_IDLE : S_FIT;
      S_FIT:    state_next = fits ? S_LOAD : S_SCAN;
      S_SCAN: begin
        if (scan_idx == SLOT_W'(NUM_SLOTS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_DECIDE;
      S_DECIDE: state_next = found ? S_EVICT : S_LOAD;
      S_EVICT:  state_next = S_FIT;
      S_LOAD:   state_next = S_IDLE;
      S_SIMPLE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    stamp_we    = 1'b0;
    stamp_waddr = id_q;
    stamp_wdata = tick;
    stamp_raddr = scan_idx;
    held_we     = 1'b0;
    held_raddr  = id_q;
    held_clr    = 1'b0;
    tier_raddr  = id_q;
    tier_we     = 1'b0;
    tier_waddr  = id_q;
    tier_wdata  = TIER_WARM;
    map_set     = 1'b0;
    emit        = 1'b0;
    emit_slot   = id_q;
    emit_status = ST_PIN_DONE;
    emit_total  = sum;
    emit_last   = 1'b1;
    unique case (state)
      S_LOOKUP: begin
        stamp_we = 1'b1;
      end
      S_CHECK: begin
        if (hit) begin
          emit        = 1'b1;
          emit_status = ST_HIT;
        end else if (!mapped[id_q]) begin
          map_set    = 1'b1;
          tier_we    = 1'b1;
          tier_wdata = TIER_WARM;
        end
      end
      S_SCAN: begin
        tier_raddr = scan_idx;
      end
      S_DECIDE: begin
        held_raddr = pick;
      end
      S_EVICT: begin
        held_clr    = 1'b1;
        tier_we     = 1'b1;
        tier_waddr  = pick;
        tier_wdata  = TIER_WARM;
        emit        = 1'b1;
        emit_slot   = pick;
        emit_status = ST_EVICTED;
        emit_total  = sum_evict;
        emit_last   = 1'b0;
      end
      S_LOAD: begin
        held_we     = 1'b1;
        tier_we     = 1'b1;
        tier_wdata  = TIER_HOT;
        emit        = 1'b1;
        emit_status = fits ? ST_LOADED : ST_OVER;
        emit_total  = sum_load;
      end
      S_SIMPLE: begin
        emit = 1'b1;
        unique case (req_q)
          REQ_MAP: begin
            if (mapped[id_q]) begin
              emit_status = ST_ALREADY;
            end else begin
              map_set     = 1'b1;
              tier_we     = 1'b1;
              tier_wdata  = TIER_WARM;
              emit_status = ST_MAPPED;
            end
          end
          REQ_PIN: begin
            stamp_we    = 1'b1;
            stamp_wdata = STAMP_MAX;
            tier_we     = 1'b1;
            tier_wdata  = TIER_PINNED;
          end
          REQ_UNPIN: begin
            stamp_we    = 1'b1;
            tier_we     = 1'b1;
            tier_wdata  = TIER_HOT;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Control and slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tick         <= '0;
      sum          <= '0;
      budget       <= BUDGET_RESET;
      mapped       <= '0;
      stamp_vld    <= '0;
      held_vld     <= '0;
      result_valid <= 1'b0;
      cmp_vld      <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tier[i] <= TIER_COLD;
      end
    end else begin
      state        <= state_next;
      result_valid <= emit;
      cmp_vld      <= (state == S_SCAN);
      if (cfg_wr && (paddr[REG_SEL_B] == REG_BUDGET)) begin
        budget <= pwdata[SUM_W-1:0];
      end
      if (state == S_LOOKUP && tick != STAMP_MAX) begin
        tick <= tick + 1'b1;
      end
      if (stamp_we) begin
        stamp_vld[stamp_waddr] <= 1'b1;
      end
      if (held_we) begin
        held_vld[id_q] <= 1'b1;
      end
      if (held_clr) begin
        held_vld[pick] <= 1'b0;
      end
      if (map_set) begin
        mapped[id_q] <= 1'b1;
      end
      if (tier_we) begin
        tier[tier_waddr] <= tier_wdata;
      end
      if (state == S_EVICT) begin
        sum <= sum_evict;
      end else if (state == S_LOAD) begin
        sum <= sum_load;
      end
    end
  end

  // Item registers, scan pipeline and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req_t'(req_type);
      id_q    <= req_slot;
      bytes_q <= block_bytes;
    end
    stamp_v_q <= stamp_vld[stamp_raddr];
    held_v_q  <= held_vld[held_raddr];
    cmp_cand  <= cand;
    cmp_idx   <= scan_idx;
    if (state == S_FIT) begin
      scan_idx <= '0;
      oldest   <= STAMP_MAX;
      found    <= 1'b0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
    // Strict compare: the lowest index wins a tie, and an all-ones stamp
    // is never picked.
    if (cmp_vld && cmp_cand && (stamp_val < oldest)) begin
      oldest <= stamp_val;
      pick   <= cmp_idx;
      found  <= 1'b1;
    end
    if (emit) begin
      slot_id        <= emit_slot;
      status         <= emit_status;
      resident_total <= emit_total;
      last           <= emit_last;
    end
  end

endmodule

### rtl/lrb_checker.sv
// ----------------------------------------------------------------------------
// lrb_checker
// Port-level checks on the result sequencing of the residency manager.
// ----------------------------------------------------------------------------
module lrb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          result_valid,
  input logic [lrb_pkg::STATUS_W-1:0]  status,
  input logic                          last
);
  import lrb_pkg::*;

  // An eviction result is always followed by more work on the same item.
  a_evict_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("eviction result shown while not busy");

  // The final result of an item leaves the block free for the next one.
  a_last_free: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy)
    else $error("busy still high on the final result");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_last_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((status == ST_EVICTED) == !last))
    else $error("last flag does not match the result status");

  // Two evictions are never reported in back-to-back cycles.
  a_evict_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> !result_valid)
    else $error("result right after an eviction");

endmodule

bind lru_residency_budget_manager lrb_checker u_lrb_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .status       (status),
  .last         (last)
);
